@@ hdl/fluorescence_transient_analyzer_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the fluorescence transient analyzer
// Concurrent checks sampled on the rising clock edge, off while in reset.
// ---------------------------------------------------------------------------
`ifndef FLUORESCENCE_TRANSIENT_ANALYZER_DEFINES_SVH
`define FLUORESCENCE_TRANSIENT_ANALYZER_DEFINES_SVH

`ifndef ASSERT_OFF
// Property holds at every edge outside reset.
`define FTA_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Condition never holds outside reset.
`define FTA_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define FTA_ASSERT(lbl, clk, rst, prop, msg)
`define FTA_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

@@ hdl/fta_pkg.sv @@
// ---------------------------------------------------------------------------
// Fluorescence transient analyzer package
// Widths, register indexes and result codes shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package fta_pkg;

  localparam int SAMPLE_BITS     = 12;
  localparam int MAX_SAMPLES     = 4096;
  localparam int RATIO_FRAC_BITS = 12;

  localparam int COUNT_BITS     = $clog2(MAX_SAMPLES + 1);
  localparam int RATIO_BITS     = RATIO_FRAC_BITS + 1;
  localparam int TIME_BITS      = 24;
  localparam int MS_BITS        = 8;
  localparam int FO_INDEX_BITS  = 12;
  localparam int LIMIT_BITS     = 13;
  localparam int HEALTH_BITS    = 2;
  localparam int FLAG_BITS      = 4;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 13;
  localparam int DIV_CNT_BITS   = $clog2(RATIO_FRAC_BITS + 1);
  localparam int US_PER_MS      = 1000;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] CFG_FO_INDEX      = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_J_TIME_MS     = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_I_TIME_MS     = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_POOR_LIMIT    = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_HEALTHY_LIMIT = 3'd4;

  // health classes
  localparam logic [HEALTH_BITS-1:0] HEALTH_POOR     = 2'd0;
  localparam logic [HEALTH_BITS-1:0] HEALTH_MODERATE = 2'd1;
  localparam logic [HEALTH_BITS-1:0] HEALTH_HEALTHY  = 2'd2;

  // capture flag bit positions
  localparam int FLAG_J_FOUND  = 0;
  localparam int FLAG_I_FOUND  = 1;
  localparam int FLAG_FO_MISS  = 2;
  localparam int FLAG_PEAK_ZERO = 3;

endpackage

`default_nettype wire

@@ hdl/fta_intf.sv @@
// ---------------------------------------------------------------------------
// Fluorescence transient analyzer channels
// Valid/ready channels for samples, results and configuration writes.
// ---------------------------------------------------------------------------
`default_nettype none

interface fta_sample_if import fta_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic [TIME_BITS-1:0]   time_us;
  logic                   last;

  modport source (output valid, sample, time_us, last, input ready);
  modport sink   (input valid, sample, time_us, last, output ready);
endinterface

interface fta_result_if import fta_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] fo_level;
  logic [TIME_BITS-1:0]   fo_time;
  logic [SAMPLE_BITS-1:0] fj_level;
  logic [TIME_BITS-1:0]   fj_time;
  logic [SAMPLE_BITS-1:0] fi_level;
  logic [TIME_BITS-1:0]   fi_time;
  logic [SAMPLE_BITS-1:0] peak_level;
  logic [SAMPLE_BITS-1:0] variable_level;
  logic [RATIO_BITS-1:0]  yield_ratio;
  logic [HEALTH_BITS-1:0] health_class;
  logic [FLAG_BITS-1:0]   capture_flags;

  modport source (output valid, fo_level, fo_time, fj_level, fj_time, fi_level, fi_time,
                  peak_level, variable_level, yield_ratio, health_class, capture_flags,
                  input ready);
  modport sink   (input valid, fo_level, fo_time, fj_level, fj_time, fi_level, fi_time,
                  peak_level, variable_level, yield_ratio, health_class, capture_flags,
                  output ready);
endinterface

interface fta_cfg_if import fta_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/fluorescence_transient_analyzer.sv @@
// ---------------------------------------------------------------------------
// Fluorescence transient analyzer
// Tracks Fo, Fj, Fi and Fm over a run and reports Fv, Fv/Fm and health.
// ---------------------------------------------------------------------------
// For an ordinary sample, counting, peak tracking and the Fo, J and I
// captures all happen at the edge that accepts it. The sample marked last
// is accepted, then Fv is formed on the shared subtractor, then the
// restoring divide of Fv/Fm runs (one quotient bit per cycle on that same
// subtractor), and a last step classifies the ratio and loads the output
// register. The next run starts as soon as the result is
// loaded; if the previous result is still waiting, the block holds until it
// is taken. Configuration writes are always accepted and should land while the
// block is idle.
`default_nettype none

`include "fluorescence_transient_analyzer_defines.svh"

module fluorescence_transient_analyzer import fta_pkg::*; (
  input  wire          clk,
  input  wire          rst,
  fta_cfg_if.sink      cfg,
  fta_sample_if.sink   samples,
  fta_result_if.source results
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FV,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration
  logic [FO_INDEX_BITS-1:0] fo_index;
  logic [MS_BITS-1:0]       j_time_ms;
  logic [MS_BITS-1:0]       i_time_ms;
  logic [LIMIT_BITS-1:0]    poor_limit;
  logic [LIMIT_BITS-1:0]    healthy_limit;

  // run state
  logic [COUNT_BITS-1:0]  sample_count;
  logic [SAMPLE_BITS-1:0] peak_value;
  logic [SAMPLE_BITS-1:0] fo_value;
  logic [TIME_BITS-1:0]   fo_stamp;
  logic                   fo_seen;
  logic [SAMPLE_BITS-1:0] fj_value;
  logic [TIME_BITS-1:0]   fj_stamp;
  logic                   fj_seen;
  logic [SAMPLE_BITS-1:0] fi_value;
  logic [TIME_BITS-1:0]   fi_stamp;
  logic                   fi_seen;

  // divider
  logic [SAMPLE_BITS-1:0]  fv;
  logic [SAMPLE_BITS:0]    rem;
  logic [RATIO_BITS-1:0]   quot;
  logic [DIV_CNT_BITS-1:0] div_cnt;

  // shared subtractor
  logic [SAMPLE_BITS:0]   sub_a;
  logic [SAMPLE_BITS:0]   sub_b;
  logic [SAMPLE_BITS+1:0] sub_diff;
  logic                   sub_borrow;

  logic                   accept;
  logic [TIME_BITS-1:0]   j_lo;
  logic [TIME_BITS-1:0]   i_lo;
  logic                   j_hit;
  logic                   i_hit;
  logic                   fo_hit;
  logic                   div_ge;
  logic [SAMPLE_BITS-1:0] div_rest;
  logic [RATIO_BITS-1:0]  ratio;
  logic [HEALTH_BITS-1:0] health;
  logic                   out_free;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign out_free      = !results.valid || results.ready;

  // whole-millisecond match as a microsecond window
  assign j_lo  = TIME_BITS'(j_time_ms) * TIME_BITS'(US_PER_MS);
  assign i_lo  = TIME_BITS'(i_time_ms) * TIME_BITS'(US_PER_MS);
  assign j_hit = (samples.time_us >= j_lo) &&
                 (samples.time_us < j_lo + TIME_BITS'(US_PER_MS));
  assign i_hit = (samples.time_us >= i_lo) &&
                 (samples.time_us < i_lo + TIME_BITS'(US_PER_MS));
  assign fo_hit = (sample_count < COUNT_BITS'(MAX_SAMPLES)) &&
                  (sample_count == COUNT_BITS'(fo_index));

  always_comb begin
    if (state == ST_FV) begin
      sub_a = {1'b0, peak_value};
      sub_b = {1'b0, fo_value};
    end else begin
      sub_a = rem;
      sub_b = {1'b0, peak_value};
    end
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[SAMPLE_BITS+1];
  assign div_ge     = !sub_borrow;
  assign div_rest   = div_ge ? sub_diff[SAMPLE_BITS-1:0] : rem[SAMPLE_BITS-1:0];

  assign ratio = (peak_value == '0) ? '0 : quot;

  always_comb begin
    if (ratio < poor_limit) begin
      health = HEALTH_POOR;
    end else if (ratio < healthy_limit) begin
      health = HEALTH_MODERATE;
    end else begin
      health = HEALTH_HEALTHY;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fo_index      <= '0;
      j_time_ms     <= MS_BITS'(2);
      i_time_ms     <= MS_BITS'(30);
      poor_limit    <= LIMIT_BITS'(2048);
      healthy_limit <= LIMIT_BITS'(2867);
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_FO_INDEX:      fo_index      <= cfg.data[FO_INDEX_BITS-1:0];
        CFG_J_TIME_MS:     j_time_ms     <= cfg.data[MS_BITS-1:0];
        CFG_I_TIME_MS:     i_time_ms     <= cfg.data[MS_BITS-1:0];
        CFG_POOR_LIMIT:    poor_limit    <= cfg.data[LIMIT_BITS-1:0];
        CFG_HEALTHY_LIMIT: healthy_limit <= cfg.data[LIMIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      results.valid <= 1'b0;
      sample_count  <= '0;
      peak_value    <= '0;
      fo_value      <= '0;
      fo_stamp      <= '0;
      fo_seen       <= 1'b0;
      fj_value      <= '0;
      fj_stamp      <= '0;
      fj_seen       <= 1'b0;
      fi_value      <= '0;
      fi_stamp      <= '0;
      fi_seen       <= 1'b0;
      div_cnt       <= '0;
    end else begin
      // drop the taken result; ST_FINISH reloads the register itself
      if (results.valid && results.ready && state != ST_FINISH) begin
        results.valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (sample_count < COUNT_BITS'(MAX_SAMPLES)) begin
              sample_count <= sample_count + 1'b1;
            end
            if (fo_hit) begin
              fo_value <= samples.sample;
              fo_stamp <= samples.time_us;
              fo_seen  <= 1'b1;
            end
            if (samples.sample > peak_value) begin
              peak_value <= samples.sample;
            end
            // a sample that takes J cannot also take I
            if (!fj_seen && j_hit) begin
              fj_value <= samples.sample;
              fj_stamp <= samples.time_us;
              fj_seen  <= 1'b1;
            end else if (!fi_seen && i_hit) begin
              fi_value <= samples.sample;
              fi_stamp <= samples.time_us;
              fi_seen  <= 1'b1;
            end
            if (samples.last) begin
              state <= ST_FV;
            end
          end
        end
        ST_FV: begin
          // clamp Fv at zero when Fo exceeds the peak
          fv      <= sub_borrow ? '0 : sub_diff[SAMPLE_BITS-1:0];
          rem     <= sub_borrow ? '0 : {1'b0, sub_diff[SAMPLE_BITS-1:0]};
          div_cnt <= DIV_CNT_BITS'(RATIO_FRAC_BITS);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          quot <= {quot[RATIO_BITS-2:0], div_ge};
          rem  <= {div_rest, 1'b0};
          if (div_cnt == '0) begin
            state <= ST_FINISH;
          end else begin
            div_cnt <= div_cnt - 1'b1;
          end
        end
        ST_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            results.valid          <= 1'b1;
            results.fo_level       <= fo_seen ? fo_value : '0;
            results.fo_time        <= fo_seen ? fo_stamp : '0;
            results.fj_level       <= fj_value;
            results.fj_time        <= fj_stamp;
            results.fi_level       <= fi_value;
            results.fi_time        <= fi_stamp;
            results.peak_level     <= peak_value;
            results.variable_level <= (peak_value == '0) ? '0 : fv;
            results.yield_ratio    <= ratio;
            results.health_class   <= health;
            results.capture_flags[FLAG_J_FOUND]   <= fj_seen;
            results.capture_flags[FLAG_I_FOUND]   <= fi_seen;
            results.capture_flags[FLAG_FO_MISS]   <= !fo_seen;
            results.capture_flags[FLAG_PEAK_ZERO] <= (peak_value == '0);
            sample_count <= '0;
            peak_value   <= '0;
            fo_value     <= '0;
            fo_stamp     <= '0;
            fo_seen      <= 1'b0;
            fj_value     <= '0;
            fj_stamp     <= '0;
            fj_seen      <= 1'b0;
            fi_value     <= '0;
            fi_stamp     <= '0;
            fi_seen      <= 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `FTA_ASSERT_NEVER(a_count_sat, clk, rst, sample_count > COUNT_BITS'(MAX_SAMPLES),
                    "sample count past saturation")
  `FTA_ASSERT(a_run_cleared, clk, rst,
              $rose(results.valid) |-> sample_count == '0 && peak_value == '0 && !fo_seen,
              "run state not cleared with result")
  `FTA_ASSERT(a_ratio_range, clk, rst,
              results.valid |-> results.yield_ratio <= RATIO_BITS'(1 << RATIO_FRAC_BITS) &&
                                results.variable_level <= results.peak_level,
              "ratio or Fv out of range")
  `FTA_ASSERT_NEVER(a_div_cnt, clk, rst, div_cnt > DIV_CNT_BITS'(RATIO_FRAC_BITS),
                    "divide step count out of range")

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Fluorescence transient analyzer testbench
// Streams timestamped sample runs into the analyzer and checks each run
// report against an in-bench prediction of Fo, Fj, Fi, Fm, Fv, Fv/Fm,
// health class and capture flags. A directed set of runs is followed by a
// long saturating run and then by random runs under changing settings and
// random stalls on both channels.
// ---------------------------------------------------------------------------
module testbench;
  import fta_pkg::*;

  localparam int unsigned TIME_MAX  = (1 << TIME_BITS) - 1;
  localparam int unsigned LEVEL_MAX = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned RATIO_ONE = 1 << RATIO_FRAC_BITS;

  typedef struct {
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   time_us;
    logic                   last;
  } sample_req_t;

  typedef struct {
    logic [SAMPLE_BITS-1:0] fo_level;
    logic [TIME_BITS-1:0]   fo_time;
    logic [SAMPLE_BITS-1:0] fj_level;
    logic [TIME_BITS-1:0]   fj_time;
    logic [SAMPLE_BITS-1:0] fi_level;
    logic [TIME_BITS-1:0]   fi_time;
    logic [SAMPLE_BITS-1:0] peak_level;
    logic [SAMPLE_BITS-1:0] variable_level;
    logic [RATIO_BITS-1:0]  yield_ratio;
    logic [HEALTH_BITS-1:0] health_class;
    logic [FLAG_BITS-1:0]   capture_flags;
  } transient_report_t;

  logic clk;
  logic rst;

  fta_cfg_if    cfg_bus ();
  fta_sample_if sample_bus ();
  fta_result_if result_bus ();

  fluorescence_transient_analyzer dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .samples (sample_bus),
    .results (result_bus)
  );

  // settings as the block should hold them
  logic [FO_INDEX_BITS-1:0] fo_index_reg = '0;
  logic [MS_BITS-1:0]       j_ms_reg     = MS_BITS'(2);
  logic [MS_BITS-1:0]       i_ms_reg     = MS_BITS'(30);
  logic [LIMIT_BITS-1:0]    poor_reg     = LIMIT_BITS'(2048);
  logic [LIMIT_BITS-1:0]    healthy_reg  = LIMIT_BITS'(2867);

  // run in progress
  logic [COUNT_BITS-1:0]  run_count = '0;
  logic [SAMPLE_BITS-1:0] run_peak  = '0;
  logic [SAMPLE_BITS-1:0] fo_val    = '0;
  logic [SAMPLE_BITS-1:0] fj_val    = '0;
  logic [SAMPLE_BITS-1:0] fi_val    = '0;
  logic [TIME_BITS-1:0]   fo_ts     = '0;
  logic [TIME_BITS-1:0]   fj_ts     = '0;
  logic [TIME_BITS-1:0]   fi_ts     = '0;
  bit                     fo_got    = 1'b0;
  bit                     fj_got    = 1'b0;
  bit                     fi_got    = 1'b0;

  sample_req_t       pending_samples[$];
  transient_report_t expected_reports[$];

  int  samples_queued = 0;
  int  samples_taken  = 0;
  int  mismatch_count = 0;
  bit  sample_fire    = 1'b0;
  int  send_idle_pct  = 0;
  int  recv_idle_pct  = 0;
  int  gap_left       = 0;
  int  stall_left     = 0;
  int  hold_order     = 0;
  int  hold_left      = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Advance the run by one accepted sample; on the last one form the report.
  task automatic absorb_sample(input sample_req_t req);
    int unsigned       ms;
    int unsigned       quot;
    logic [SAMPLE_BITS-1:0] fv;
    transient_report_t rep;
    ms = req.time_us / US_PER_MS;
    if (run_count < MAX_SAMPLES) begin
      if (run_count == fo_index_reg) begin
        fo_val = req.sample;
        fo_ts  = req.time_us;
        fo_got = 1'b1;
      end
      run_count++;
    end
    if (req.sample > run_peak) run_peak = req.sample;
    // a sample that takes J cannot also take I
    if (!fj_got && ms == j_ms_reg) begin
      fj_val = req.sample;
      fj_ts  = req.time_us;
      fj_got = 1'b1;
    end else if (!fi_got && ms == i_ms_reg) begin
      fi_val = req.sample;
      fi_ts  = req.time_us;
      fi_got = 1'b1;
    end
    if (req.last) begin
      fv   = (run_peak > fo_val) ? run_peak - fo_val : '0;
      quot = 0;
      if (run_peak != 0) quot = (int'(fv) << RATIO_FRAC_BITS) / run_peak;
      rep.fo_level       = fo_got ? fo_val : '0;
      rep.fo_time        = fo_got ? fo_ts : '0;
      rep.fj_level       = fj_val;
      rep.fj_time        = fj_ts;
      rep.fi_level       = fi_val;
      rep.fi_time        = fi_ts;
      rep.peak_level     = run_peak;
      rep.variable_level = fv;
      rep.yield_ratio    = RATIO_BITS'(quot);
      if (quot < poor_reg) rep.health_class = HEALTH_POOR;
      else if (quot < healthy_reg) rep.health_class = HEALTH_MODERATE;
      else rep.health_class = HEALTH_HEALTHY;
      rep.capture_flags                 = '0;
      rep.capture_flags[FLAG_J_FOUND]   = fj_got;
      rep.capture_flags[FLAG_I_FOUND]   = fi_got;
      rep.capture_flags[FLAG_FO_MISS]   = !fo_got;
      rep.capture_flags[FLAG_PEAK_ZERO] = (run_peak == 0);
      expected_reports.push_back(rep);
      run_count = '0;
      run_peak  = '0;
      fo_val = '0; fo_ts = '0; fo_got = 1'b0;
      fj_val = '0; fj_ts = '0; fj_got = 1'b0;
      fi_val = '0; fi_ts = '0; fi_got = 1'b0;
    end
  endtask

  function automatic void check_field(input string name, input logic [TIME_BITS-1:0] want,
                                      input logic [TIME_BITS-1:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // sample side: take the request at the rising edge
  always @(posedge clk) begin
    sample_req_t req;
    sample_fire = !rst && sample_bus.valid && sample_bus.ready;
    if (sample_fire) begin
      req.sample  = sample_bus.sample;
      req.time_us = sample_bus.time_us;
      req.last    = sample_bus.last;
      absorb_sample(req);
      samples_taken++;
    end
  end

  // sample driver: hold the request until taken, then idle or advance
  always @(negedge clk) begin
    sample_req_t item;
    if (rst) begin
      sample_bus.valid <= 1'b0;
    end else if (sample_fire || !sample_bus.valid) begin
      if (gap_left == 0 && $urandom_range(1, 100) <= send_idle_pct)
        gap_left = $urandom_range(1, 19);
      if (gap_left > 0) begin
        gap_left--;
        sample_bus.valid <= 1'b0;
      end else if (pending_samples.size() > 0) begin
        item = pending_samples.pop_front();
        sample_bus.valid   <= 1'b1;
        sample_bus.sample  <= item.sample;
        sample_bus.time_us <= item.time_us;
        sample_bus.last    <= item.last;
      end else begin
        sample_bus.valid <= 1'b0;
      end
    end
  end

  // result receiver: long hold when ordered, otherwise random stall bursts
  always @(negedge clk) begin
    if (rst) begin
      result_bus.ready <= 1'b0;
    end else begin
      if (hold_order > 0) begin
        hold_left  = hold_order;
        hold_order = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        if (stall_left == 0 && $urandom_range(1, 100) <= recv_idle_pct)
          stall_left = $urandom_range(1, 19);
        if (stall_left > 0) begin
          stall_left--;
          result_bus.ready <= 1'b0;
        end else begin
          result_bus.ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    transient_report_t want;
    if (!rst && result_bus.valid && result_bus.ready) begin
      if (expected_reports.size() == 0) begin
        $display("%0t: report with nothing expected, expected none got peak_level %0d",
                 $time, result_bus.peak_level);
        mismatch_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("fo_level", want.fo_level, result_bus.fo_level);
        check_field("fo_time", want.fo_time, result_bus.fo_time);
        check_field("fj_level", want.fj_level, result_bus.fj_level);
        check_field("fj_time", want.fj_time, result_bus.fj_time);
        check_field("fi_level", want.fi_level, result_bus.fi_level);
        check_field("fi_time", want.fi_time, result_bus.fi_time);
        check_field("peak_level", want.peak_level, result_bus.peak_level);
        check_field("variable_level", want.variable_level, result_bus.variable_level);
        check_field("yield_ratio", want.yield_ratio, result_bus.yield_ratio);
        check_field("health_class", want.health_class, result_bus.health_class);
        check_field("capture_flags", want.capture_flags, result_bus.capture_flags);
      end
    end
  end

  task automatic queue_item(input int unsigned s, input int unsigned t, input bit last);
    sample_req_t req;
    req.sample  = SAMPLE_BITS'(s);
    req.time_us = TIME_BITS'(t);
    req.last    = last;
    pending_samples.push_back(req);
    samples_queued++;
  endtask

  // One run of n samples: a rising trace with steps into the J and I windows,
  // or scrambled levels and timestamps when noisy.
  task automatic queue_run(input int n, input bit noisy);
    int unsigned t;
    int unsigned s;
    int unsigned base;
    int unsigned top;
    int unsigned hop;
    bit          flat_zero;
    t         = $urandom_range(0, 600);
    base      = $urandom_range(0, 1500);
    top       = ($urandom_range(0, 7) == 0) ? LEVEL_MAX : $urandom_range(base, LEVEL_MAX);
    flat_zero = ($urandom_range(0, 24) == 0);
    for (int k = 0; k < n; k++) begin
      if (noisy) begin
        s = $urandom_range(0, LEVEL_MAX);
        t = $urandom_range(0, 1) ? $urandom_range(0, TIME_MAX) : $urandom_range(0, 60000);
      end else begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: t += $urandom_range(1, 400);
          5, 6: begin
            hop = j_ms_reg * US_PER_MS + $urandom_range(0, US_PER_MS - 1);
            t   = (hop > t) ? hop : t + $urandom_range(1, 400);
          end
          7: begin
            hop = i_ms_reg * US_PER_MS + $urandom_range(0, US_PER_MS - 1);
            t   = (hop > t) ? hop : t + $urandom_range(1, 400);
          end
          8: ; // repeat the timestamp
          default: t += $urandom_range(1000, 20000);
        endcase
        if (t > TIME_MAX) t = TIME_MAX;
        s = flat_zero ? 0 : base + ((top - base) * k) / n + $urandom_range(0, 40);
        if (s > LEVEL_MAX) s = LEVEL_MAX;
      end
      queue_item(s, t, k == n - 1);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= CFG_DATA_BITS'(value);
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_FO_INDEX:      fo_index_reg = FO_INDEX_BITS'(value);
      CFG_J_TIME_MS:     j_ms_reg     = MS_BITS'(value);
      CFG_I_TIME_MS:     i_ms_reg     = MS_BITS'(value);
      CFG_POOR_LIMIT:    poor_reg     = LIMIT_BITS'(value);
      CFG_HEALTHY_LIMIT: healthy_reg  = LIMIT_BITS'(value);
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Hold the sender until every report is back, then let the divide settle.
  task automatic drain();
    do @(negedge clk); while (samples_taken != samples_queued || expected_reports.size() != 0);
    repeat (24) @(posedge clk);
  endtask

  task automatic shuffle_settings();
    int unsigned r;
    int unsigned lo;
    int unsigned hi;
    int unsigned swap;
    r = $urandom_range(0, 9);
    write_reg(CFG_FO_INDEX, (r < 7) ? $urandom_range(0, 6) :
                            (r < 9) ? $urandom_range(0, 4095) : 4095);
    r = $urandom_range(0, 9);
    write_reg(CFG_J_TIME_MS, (r < 7) ? $urandom_range(0, 40) :
                             (r < 9) ? $urandom_range(0, 255) : ((r & 1) ? 255 : 0));
    r = $urandom_range(0, 9);
    write_reg(CFG_I_TIME_MS, (r < 2) ? j_ms_reg :
                             (r < 8) ? $urandom_range(0, 60) : $urandom_range(0, 255));
    lo = $urandom_range(0, RATIO_ONE);
    hi = $urandom_range(0, RATIO_ONE);
    if (lo > hi && $urandom_range(0, 4) != 0) begin
      swap = lo; lo = hi; hi = swap;
    end
    r = $urandom_range(0, 9);
    if (r == 0) lo = 0;
    if (r == 1) hi = RATIO_ONE;
    if (r == 2) lo = RATIO_ONE;
    write_reg(CFG_POOR_LIMIT, lo);
    write_reg(CFG_HEALTHY_LIMIT, hi);
  endtask

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return 4;
      2:       return 12;
      default: return 30;
    endcase
  endfunction

  initial begin
    int random_total;
    int phase;
    int quota;
    int n;
    rst                = 1'b1;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_FO_INDEX;
    cfg_bus.data       = '0;
    sample_bus.valid   = 1'b0;
    sample_bus.sample  = '0;
    sample_bus.time_us = '0;
    sample_bus.last    = 1'b0;
    result_bus.ready   = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: zero peak, full J and I capture, extreme levels and times
    queue_item(0, 0, 1);
    queue_item(0, 1999, 0);
    queue_item(4095, 2000, 0);
    queue_item(100, 2999, 0);
    queue_item(200, 29999, 0);
    queue_item(300, 30000, 0);
    queue_item(400, 30999, 0);
    queue_item(500, 31000, 1);
    queue_item(4095, TIME_MAX, 1);
    queue_item(2048, 500, 0);
    queue_item(4095, 2000, 0);
    queue_item(3000, 30500, 1);
    queue_item(1000, 100, 0);
    queue_item(2500, 2100, 1);
    drain();

    // J and I in the same millisecond; Fo index past the end of a short run
    write_reg(CFG_J_TIME_MS, 5);
    write_reg(CFG_I_TIME_MS, 5);
    write_reg(CFG_FO_INDEX, 3);
    queue_item(10, 5000, 0);
    queue_item(20, 5001, 0);
    queue_item(30, 5002, 0);
    queue_item(40, 6000, 1);
    queue_item(7, 5999, 0);
    queue_item(8, 100, 1);
    drain();

    // threshold and window extremes
    write_reg(CFG_FO_INDEX, 0);
    write_reg(CFG_J_TIME_MS, 0);
    write_reg(CFG_I_TIME_MS, 255);
    write_reg(CFG_POOR_LIMIT, 0);
    write_reg(CFG_HEALTHY_LIMIT, 0);
    queue_item(0, 999, 0);
    queue_item(3000, 255999, 0);
    queue_item(1, 0, 1);
    queue_item(5, 10, 1);
    drain();
    write_reg(CFG_FO_INDEX, 4095);
    write_reg(CFG_POOR_LIMIT, RATIO_ONE);
    write_reg(CFG_HEALTHY_LIMIT, RATIO_ONE);
    queue_item(100, 1, 0);
    queue_item(50, 2, 1);
    drain();

    // saturating run: Fo at the top index, J, I and peak only after saturation
    write_reg(CFG_J_TIME_MS, 200);
    write_reg(CFG_I_TIME_MS, 200);
    for (int k = 0; k < MAX_SAMPLES; k++)
      queue_item(k % 97, k * 10, 0);
    queue_item(50, 200000, 0);
    queue_item(60, 200010, 0);
    queue_item(4095, 200020, 0);
    queue_item(7, 200030, 1);
    drain();

    random_total = 0;
    phase        = 0;
    while (random_total < 1450) begin
      shuffle_settings();
      if (random_total > 1150) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = pick_idle_pct();
        recv_idle_pct = pick_idle_pct();
      end
      if (phase == 2) begin
        // stall the receiver while short runs keep coming, so the input backs up
        hold_order = 400;
        repeat (12) begin
          queue_run(3, 1'b0);
          random_total += 3;
        end
      end else begin
        quota = $urandom_range(80, 160);
        while (quota > 0) begin
          case ($urandom_range(0, 19))
            0:       n = 1;
            1:       n = $urandom_range(60, 200);
            default: n = $urandom_range(2, 30);
          endcase
          queue_run(n, $urandom_range(0, 9) == 0);
          quota        -= n;
          random_total += n;
        end
      end
      drain();
      phase++;
    end

    if (mismatch_count == 0 && expected_reports.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/fta_pkg.sv
hdl/fta_intf.sv
hdl/fluorescence_transient_analyzer.sv
tb/sv/testbench.sv
